// ===== rtl/pfa_pkg.sv =====
// Shared types and constants for the page frame allocator.
// No dependencies; used by every module under rtl/ except pfa_stack_ram.
package pfa_pkg;

    // Pages tracked by the free stack.
    localparam int PAGE_COUNT = 4096;
    localparam int ADDR_W     = $clog2(PAGE_COUNT);
    localparam int CNT_W      = $clog2(PAGE_COUNT + 1);

    // Fixed field widths at the ports.
    localparam int CMD_W      = 2;
    localparam int KIND_W     = 2;
    localparam int PAGE_W     = 12;
    localparam int REQ_W      = 16;
    localparam int STATUS_W   = 2;
    localparam int OUT_CNT_W  = 13;
    localparam int KRES_W     = 16;

    // Wide enough for reserved + request + kernel reserve without overflow.
    localparam int SUM_W = ((CNT_W > REQ_W) ? CNT_W : REQ_W) + 2;

    localparam logic [KRES_W-1:0] KRES_AT_RESET = KRES_W'(1024);

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC     = 2'd0,
        CMD_FREE      = 2'd1,
        CMD_RESERVE   = 2'd2,
        CMD_UNRESERVE = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_NOMEM = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // alloc_kind bits
    localparam int KIND_RESV_BIT = 0;
    localparam int KIND_ACCT_BIT = 1;

    // Stack memory access for one command.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [PAGE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // Outcome of one command, less the popped page.
    typedef struct packed {
        t_status              status;
        logic                 pop;
        logic [OUT_CNT_W-1:0] free_pages;
        logic [OUT_CNT_W-1:0] reserved_pages;
    } t_res;

endpackage

// ===== rtl/pfa_stack_ram.sv =====
// Single-port-write, single-port-read synchronous RAM, registered read data.
// Generic; no package dependency.
module pfa_stack_ram #(
    parameter int DEPTH  = 4096,
    parameter int WIDTH  = 12,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pfa_ctrl.sv =====
// Command decode, free/reserved counters and kernel reserve register.
// Depends on pfa_pkg; drives the stack RAM request.
module pfa_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_go,
    input  logic [pfa_pkg::CMD_W-1:0]    i_command,
    input  logic [pfa_pkg::KIND_W-1:0]   i_alloc_kind,
    input  logic [pfa_pkg::PAGE_W-1:0]   i_page_index,
    input  logic [pfa_pkg::REQ_W-1:0]    i_request_count,
    input  logic                         i_cfg_we,
    input  logic [pfa_pkg::KRES_W-1:0]   i_cfg_data,
    output pfa_pkg::t_res                o_res,
    output pfa_pkg::t_mem_req            o_mem
);

    logic [pfa_pkg::CNT_W-1:0]  r_fc, n_fc;
    logic [pfa_pkg::CNT_W-1:0]  r_rc, n_rc;
    logic [pfa_pkg::KRES_W-1:0] r_kr;

    logic [pfa_pkg::SUM_W-1:0]  sum_ak;
    logic [pfa_pkg::SUM_W-1:0]  sum_req;
    logic [pfa_pkg::SUM_W-1:0]  fc_w;
    pfa_pkg::t_status           status;
    logic                       pop;
    pfa_pkg::t_mem_req          mem;

    always_comb begin
        n_fc    = r_fc;
        n_rc    = r_rc;
        status  = pfa_pkg::ST_OK;
        pop     = 1'b0;
        mem     = '0;
        sum_ak  = pfa_pkg::SUM_W'(r_rc) + pfa_pkg::SUM_W'(r_kr);
        sum_req = sum_ak + pfa_pkg::SUM_W'(i_request_count);
        fc_w    = pfa_pkg::SUM_W'(r_fc);
        case (pfa_pkg::t_cmd'(i_command))
            pfa_pkg::CMD_ALLOC: begin
                if (r_fc == '0) begin
                    status = pfa_pkg::ST_NOMEM;
                end else if (!i_alloc_kind[pfa_pkg::KIND_RESV_BIT] &&
                             i_alloc_kind[pfa_pkg::KIND_ACCT_BIT] && sum_ak >= fc_w) begin
                    status = pfa_pkg::ST_NOMEM;
                end else begin
                    if (i_alloc_kind[pfa_pkg::KIND_RESV_BIT] && r_rc != '0) begin
                        n_rc = r_rc - 1'b1;
                    end
                    n_fc      = r_fc - 1'b1;
                    pop       = 1'b1;
                    mem.re    = 1'b1;
                    mem.raddr = n_fc[pfa_pkg::ADDR_W-1:0];
                end
            end
            pfa_pkg::CMD_FREE: begin
                if (r_fc == pfa_pkg::CNT_W'(pfa_pkg::PAGE_COUNT)) begin
                    status = pfa_pkg::ST_FULL;
                end else begin
                    if (i_alloc_kind[pfa_pkg::KIND_RESV_BIT] &&
                        r_rc < pfa_pkg::CNT_W'(pfa_pkg::PAGE_COUNT)) begin
                        n_rc = r_rc + 1'b1;
                    end
                    mem.we    = 1'b1;
                    mem.waddr = r_fc[pfa_pkg::ADDR_W-1:0];
                    mem.wdata = i_page_index;
                    n_fc      = r_fc + 1'b1;
                end
            end
            pfa_pkg::CMD_RESERVE: begin
                if (sum_req > fc_w) begin
                    status = pfa_pkg::ST_NOMEM;
                end else begin
                    // bounded by free count, so the truncation is exact
                    n_rc = r_rc + pfa_pkg::CNT_W'(i_request_count);
                end
            end
            pfa_pkg::CMD_UNRESERVE: begin
                if (pfa_pkg::SUM_W'(i_request_count) >= pfa_pkg::SUM_W'(r_rc)) begin
                    n_rc = '0;
                end else begin
                    n_rc = r_rc - pfa_pkg::CNT_W'(i_request_count);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc <= '0;
            r_rc <= '0;
            r_kr <= pfa_pkg::KRES_AT_RESET;
        end else begin
            if (i_go) begin
                r_fc <= n_fc;
                r_rc <= n_rc;
            end
            if (i_cfg_we) begin
                r_kr <= i_cfg_data;
            end
        end
    end

    assign o_res.status         = status;
    assign o_res.pop            = pop;
    assign o_res.free_pages     = pfa_pkg::OUT_CNT_W'(n_fc);
    assign o_res.reserved_pages = pfa_pkg::OUT_CNT_W'(n_rc);

    assign o_mem.we    = mem.we & i_go;
    assign o_mem.waddr = mem.waddr;
    assign o_mem.wdata = mem.wdata;
    assign o_mem.re    = mem.re & i_go;
    assign o_mem.raddr = mem.raddr;

endmodule

// ===== rtl/page_frame_allocator_with_reserve.sv =====
// Page frame allocator, top level: free stack RAM, control and result register.
// Depends on pfa_pkg, pfa_stack_ram and pfa_ctrl.
// The result register is loaded from stage P in the cycle after the command is taken.
// A new command waits until the read stage (stage P) has drained and the result slot is free.
// Reset (synchronous, active low): counters cleared, kernel reserve 1024, no result pending;
// stack RAM contents are not cleared and need no clearing pass.
module page_frame_allocator_with_reserve (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [pfa_pkg::CMD_W-1:0]     i_command,
    input  logic [pfa_pkg::KIND_W-1:0]    i_alloc_kind,
    input  logic [pfa_pkg::PAGE_W-1:0]    i_page_index,
    input  logic [pfa_pkg::REQ_W-1:0]     i_request_count,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pfa_pkg::STATUS_W-1:0]  o_status,
    output logic [pfa_pkg::PAGE_W-1:0]    o_allocated_page,
    output logic [pfa_pkg::OUT_CNT_W-1:0] o_free_pages,
    output logic [pfa_pkg::OUT_CNT_W-1:0] o_reserved_pages,
    // kernel reserve write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pfa_pkg::KRES_W-1:0]    i_cfg_data
);

    pfa_pkg::t_res     res;
    pfa_pkg::t_mem_req mem;
    logic [pfa_pkg::PAGE_W-1:0] rdata;

    // Stage P: command decided, counters updated, RAM read in flight.
    logic          r_p_vld;
    pfa_pkg::t_res r_p_res;

    // Result register.
    logic                          r_o_vld;
    logic [pfa_pkg::STATUS_W-1:0]  r_o_status;
    logic [pfa_pkg::PAGE_W-1:0]    r_o_page;
    logic [pfa_pkg::OUT_CNT_W-1:0] r_o_free;
    logic [pfa_pkg::OUT_CNT_W-1:0] r_o_resv;

    logic go;
    logic out_free;

    // Result slot is free next cycle if empty now or its transaction completes now.
    assign out_free   = !r_o_vld || i_out_ready;
    // Only one command in flight: stage P always drains into the result register.
    assign o_in_ready = !r_p_vld && out_free;
    assign go         = i_in_valid && o_in_ready;

    // Kernel reserve writes are always taken; the user must send them only while idle, the block does not enforce it.
    assign o_cfg_ready = 1'b1;

    pfa_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_go            (go),
        .i_command       (i_command),
        .i_alloc_kind    (i_alloc_kind),
        .i_page_index    (i_page_index),
        .i_request_count (i_request_count),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .o_res           (res),
        .o_mem           (mem)
    );

    // Push writes at the edge it is decided; the next command is not taken until stage P
    // has drained, so a freed page is always visible to the next alloc.
    pfa_stack_ram #(
        .DEPTH (pfa_pkg::PAGE_COUNT),
        .WIDTH (pfa_pkg::PAGE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_re    (mem.re),
        .i_raddr (mem.raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_p_vld <= go;
            if (r_p_vld) begin
                r_o_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_p_res <= res;
        end
        if (r_p_vld) begin
            r_o_status <= r_p_res.status;
            r_o_page   <= r_p_res.pop ? rdata : '0;
            r_o_free   <= r_p_res.free_pages;
            r_o_resv   <= r_p_res.reserved_pages;
        end
    end

    assign o_out_valid      = r_o_vld;
    assign o_status         = r_o_status;
    assign o_allocated_page = r_o_page;
    assign o_free_pages     = r_o_free;
    assign o_reserved_pages = r_o_resv;

endmodule

// ===== rtl/pfa_checker.sv =====
// Port-level checks for the page frame allocator, bound to the top level.
// Depends on pfa_pkg and page_frame_allocator_with_reserve.
module pfa_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [pfa_pkg::STATUS_W-1:0]  o_status,
    input logic [pfa_pkg::PAGE_W-1:0]    o_allocated_page,
    input logic [pfa_pkg::OUT_CNT_W-1:0] o_free_pages
);

    // Stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status) &&
        $stable(o_allocated_page) && $stable(o_free_pages))
        else $error("result changed while stalled");

    // No new command while a result is stalled.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("command taken while result stalled");

    // A failed command never reports a page.
    a_fail_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != pfa_pkg::ST_OK |-> o_allocated_page == '0)
        else $error("page reported on failed command");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status == pfa_pkg::ST_OK || o_status == pfa_pkg::ST_NOMEM ||
        o_status == pfa_pkg::ST_FULL)
        else $error("status code out of range");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind page_frame_allocator_with_reserve pfa_checker u_pfa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_status         (o_status),
    .o_allocated_page (o_allocated_page),
    .o_free_pages     (o_free_pages)
);

// ===== sim/page_frame_allocator_with_reserve_test.sv =====
// Self-checking bench for the page frame allocator with reserve.
// Depends on pfa_pkg and page_frame_allocator_with_reserve; a class predicts each result.
module page_frame_allocator_with_reserve_test;

    localparam logic [pfa_pkg::KIND_W-1:0] KIND_PLAIN = 2'b00;
    localparam logic [pfa_pkg::KIND_W-1:0] KIND_RESV  = 2'b01;
    localparam logic [pfa_pkg::KIND_W-1:0] KIND_ACCT  = 2'b10;
    localparam logic [pfa_pkg::KIND_W-1:0] KIND_BOTH  = 2'b11;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        pfa_pkg::t_status              status;
        logic [pfa_pkg::PAGE_W-1:0]    page;
        logic [pfa_pkg::OUT_CNT_W-1:0] free_pages;
        logic [pfa_pkg::OUT_CNT_W-1:0] reserved_pages;
    } t_alloc_outcome;

    // Shadow copy of the allocator: stack, counters and kernel reserve.
    class t_frame_ledger;
        logic [pfa_pkg::PAGE_W-1:0] stack [pfa_pkg::PAGE_COUNT];
        int free_count;
        int reserved_count;
        int kernel_reserve;
        int failures;
        t_alloc_outcome pending_outcomes[$];

        function new();
            free_count     = 0;
            reserved_count = 0;
            kernel_reserve = int'(pfa_pkg::KRES_AT_RESET);
            failures       = 0;
        endfunction

        // Work out the result of an accepted command and queue it.
        function void note_command(pfa_pkg::t_cmd cmd, logic [pfa_pkg::KIND_W-1:0] kind,
                                   logic [pfa_pkg::PAGE_W-1:0] page,
                                   logic [pfa_pkg::REQ_W-1:0] req);
            t_alloc_outcome o;
            int want;
            want     = int'(req);
            o.status = pfa_pkg::ST_OK;
            o.page   = '0;
            case (cmd)
                pfa_pkg::CMD_ALLOC: begin
                    if (free_count == 0) begin
                        o.status = pfa_pkg::ST_NOMEM;
                    end else if (!kind[pfa_pkg::KIND_RESV_BIT] &&
                                 kind[pfa_pkg::KIND_ACCT_BIT] &&
                                 reserved_count + kernel_reserve >= free_count) begin
                        o.status = pfa_pkg::ST_NOMEM;
                    end else begin
                        if (kind[pfa_pkg::KIND_RESV_BIT] && reserved_count > 0)
                            reserved_count--;
                        free_count--;
                        o.page = stack[free_count];
                    end
                end
                pfa_pkg::CMD_FREE: begin
                    if (free_count >= pfa_pkg::PAGE_COUNT) begin
                        o.status = pfa_pkg::ST_FULL;
                    end else begin
                        if (kind[pfa_pkg::KIND_RESV_BIT] &&
                            reserved_count < pfa_pkg::PAGE_COUNT)
                            reserved_count++;
                        stack[free_count] = page;
                        free_count++;
                    end
                end
                pfa_pkg::CMD_RESERVE: begin
                    if (reserved_count + want + kernel_reserve > free_count)
                        o.status = pfa_pkg::ST_NOMEM;
                    else
                        reserved_count += want;
                end
                default: begin
                    reserved_count = (want >= reserved_count) ? 0 : reserved_count - want;
                end
            endcase
            o.free_pages     = pfa_pkg::OUT_CNT_W'(free_count);
            o.reserved_pages = pfa_pkg::OUT_CNT_W'(reserved_count);
            pending_outcomes.push_back(o);
        endfunction

        function void flag(string what);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("%s", what);
        endfunction

        function void check_outcome(logic [pfa_pkg::STATUS_W-1:0] status,
                                    logic [pfa_pkg::PAGE_W-1:0] page,
                                    logic [pfa_pkg::OUT_CNT_W-1:0] free_pages,
                                    logic [pfa_pkg::OUT_CNT_W-1:0] reserved_pages);
            t_alloc_outcome w;
            if (pending_outcomes.size() == 0) begin
                flag($sformatf("result with none pending: st %0d page %0d free %0d resv %0d",
                               status, page, free_pages, reserved_pages));
                return;
            end
            w = pending_outcomes.pop_front();
            if (status !== w.status || page !== w.page || free_pages !== w.free_pages ||
                reserved_pages !== w.reserved_pages)
                flag($sformatf({"exp st %0d page %0d free %0d resv %0d, ",
                                "got st %0d page %0d free %0d resv %0d"},
                               w.status, w.page, w.free_pages, w.reserved_pages,
                               status, page, free_pages, reserved_pages));
        endfunction
    endclass

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          i_in_valid      = 1'b0;
    logic                          o_in_ready;
    logic [pfa_pkg::CMD_W-1:0]     i_command       = '0;
    logic [pfa_pkg::KIND_W-1:0]    i_alloc_kind    = '0;
    logic [pfa_pkg::PAGE_W-1:0]    i_page_index    = '0;
    logic [pfa_pkg::REQ_W-1:0]     i_request_count = '0;
    logic                          o_out_valid;
    logic                          i_out_ready     = 1'b0;
    logic [pfa_pkg::STATUS_W-1:0]  o_status;
    logic [pfa_pkg::PAGE_W-1:0]    o_allocated_page;
    logic [pfa_pkg::OUT_CNT_W-1:0] o_free_pages;
    logic [pfa_pkg::OUT_CNT_W-1:0] o_reserved_pages;
    logic                          i_cfg_valid     = 1'b0;
    logic                          o_cfg_ready;
    logic [pfa_pkg::KRES_W-1:0]    i_cfg_data      = '0;

    t_frame_ledger ledger = new();
    bit            steady_flow = 1'b0;   // no idling on either side while set
    int            out_stall   = 0;
    int unsigned   cycle_count = 0;

    page_frame_allocator_with_reserve dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_alloc_kind    (i_alloc_kind),
        .i_page_index    (i_page_index),
        .i_request_count (i_request_count),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_allocated_page(o_allocated_page),
        .o_free_pages    (o_free_pages),
        .o_reserved_pages(o_reserved_pages),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Mostly short gaps, the odd long one.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 16);
    endfunction

    // Result side: random back-pressure, check every result transaction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                ledger.check_outcome(o_status, o_allocated_page, o_free_pages,
                                     o_reserved_pages);
            if (out_stall > 0) begin
                i_out_ready <= 1'b0;
                out_stall   = out_stall - 1;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    out_stall = idle_cycles();
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("page_frame_allocator_with_reserve: mismatch");
            $finish;
        end
    end

    // One command transaction; valid stays up into the next call unless a gap is taken.
    task automatic issue(pfa_pkg::t_cmd cmd, logic [pfa_pkg::KIND_W-1:0] kind,
                         logic [pfa_pkg::PAGE_W-1:0] page, logic [pfa_pkg::REQ_W-1:0] req);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_command       <= cmd;
        i_alloc_kind    <= kind;
        i_page_index    <= page;
        i_request_count <= req;
        do @(posedge i_clk); while (!o_in_ready);
        ledger.note_command(cmd, kind, page, req);
    endtask

    // Hold the sender until every outstanding result has arrived.
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (ledger.pending_outcomes.size() != 0);
    endtask

    task automatic set_reserve(logic [pfa_pkg::KRES_W-1:0] value);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        ledger.kernel_reserve = int'(value);
    endtask

    // Walk the free count to a level with frees and unaccounted allocs.
    task automatic move_to(int level, bit resv_frees);
        logic [pfa_pkg::KIND_W-1:0] kind;
        while (ledger.free_count != level) begin
            kind = pfa_pkg::KIND_W'($urandom_range(0, 3));
            if (ledger.free_count < level) begin
                if (resv_frees) kind[pfa_pkg::KIND_RESV_BIT] = 1'b1;
                issue(pfa_pkg::CMD_FREE, kind, pfa_pkg::PAGE_W'($urandom_range(0, 4095)),
                      pfa_pkg::REQ_W'($urandom_range(0, 65535)));
            end else begin
                if (kind == KIND_ACCT) kind = KIND_PLAIN;
                issue(pfa_pkg::CMD_ALLOC, kind, pfa_pkg::PAGE_W'($urandom_range(0, 4095)),
                      pfa_pkg::REQ_W'($urandom_range(0, 65535)));
            end
        end
    endtask

    // Random mix drifting around a target free level; reserve requests hit the boundary often.
    task automatic wander(int count, int level);
        int r;
        int room;
        pfa_pkg::t_cmd cmd;
        logic [pfa_pkg::REQ_W-1:0] req;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (ledger.free_count < level)
                cmd = (r < 40) ? pfa_pkg::CMD_FREE : (r < 70) ? pfa_pkg::CMD_ALLOC :
                      (r < 88) ? pfa_pkg::CMD_RESERVE : pfa_pkg::CMD_UNRESERVE;
            else
                cmd = (r < 25) ? pfa_pkg::CMD_FREE : (r < 70) ? pfa_pkg::CMD_ALLOC :
                      (r < 88) ? pfa_pkg::CMD_RESERVE : pfa_pkg::CMD_UNRESERVE;
            room = ledger.free_count - ledger.reserved_count - ledger.kernel_reserve;
            r = $urandom_range(0, 99);
            if (cmd == pfa_pkg::CMD_RESERVE && r < 40)
                req = pfa_pkg::REQ_W'($urandom_range(0, 16));
            else if (cmd == pfa_pkg::CMD_RESERVE && r < 65 && room >= 0)
                req = pfa_pkg::REQ_W'(room + $urandom_range(0, 1));
            else if (cmd == pfa_pkg::CMD_UNRESERVE && r < 70)
                req = pfa_pkg::REQ_W'($urandom_range(0, 32));
            else
                req = pfa_pkg::REQ_W'($urandom_range(0, 65535));
            issue(cmd, pfa_pkg::KIND_W'($urandom_range(0, 3)),
                  pfa_pkg::PAGE_W'($urandom_range(0, 4095)), req);
        end
    endtask

    initial begin
        int level;
        logic [pfa_pkg::KRES_W-1:0] kres;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty stack, refused reserves, kinds, saturation of the reserve count.
        issue(pfa_pkg::CMD_ALLOC,     KIND_PLAIN, 12'h000, 16'h0000);
        issue(pfa_pkg::CMD_ALLOC,     KIND_BOTH,  12'h000, 16'h0000);   // empty, reserve bit
        issue(pfa_pkg::CMD_RESERVE,   KIND_PLAIN, 12'h000, 16'h0000);
        issue(pfa_pkg::CMD_UNRESERVE, KIND_PLAIN, 12'h000, 16'hFFFF);
        issue(pfa_pkg::CMD_FREE,      KIND_PLAIN, 12'hFFF, 16'h0000);
        issue(pfa_pkg::CMD_FREE,      KIND_RESV,  12'h000, 16'h0000);
        issue(pfa_pkg::CMD_FREE,      KIND_ACCT,  12'hAAA, 16'h0000);
        issue(pfa_pkg::CMD_FREE,      KIND_BOTH,  12'h555, 16'h0000);
        issue(pfa_pkg::CMD_ALLOC,     KIND_ACCT,  12'h000, 16'h0000);   // kernel reserve blocks
        issue(pfa_pkg::CMD_ALLOC,     KIND_RESV,  12'h000, 16'h0000);
        issue(pfa_pkg::CMD_ALLOC,     KIND_PLAIN, 12'h000, 16'h0000);
        issue(pfa_pkg::CMD_RESERVE,   KIND_PLAIN, 12'h000, 16'hFFFF);
        set_reserve('0);
        issue(pfa_pkg::CMD_RESERVE,   KIND_PLAIN, 12'h000, 16'h0001);
        issue(pfa_pkg::CMD_RESERVE,   KIND_PLAIN, 12'h000, 16'h0001);
        issue(pfa_pkg::CMD_ALLOC,     KIND_ACCT,  12'h000, 16'h0000);   // reserved equals free
        issue(pfa_pkg::CMD_UNRESERVE, KIND_PLAIN, 12'h000, 16'h0001);
        issue(pfa_pkg::CMD_ALLOC,     KIND_ACCT,  12'h000, 16'h0000);
        issue(pfa_pkg::CMD_ALLOC,     KIND_BOTH,  12'h000, 16'h0000);
        issue(pfa_pkg::CMD_ALLOC,     KIND_RESV,  12'h000, 16'h0000);
        issue(pfa_pkg::CMD_FREE,      KIND_RESV,  12'h123, 16'h0000);
        issue(pfa_pkg::CMD_UNRESERVE, KIND_PLAIN, 12'h000, 16'h0000);
        issue(pfa_pkg::CMD_ALLOC,     KIND_PLAIN, 12'h000, 16'h0000);
        issue(pfa_pkg::CMD_FREE,      KIND_PLAIN, 12'hFFF, 16'h0000);
        issue(pfa_pkg::CMD_UNRESERVE, KIND_PLAIN, 12'h000, 16'h0001);
        issue(pfa_pkg::CMD_ALLOC,     KIND_RESV,  12'h000, 16'h0000);   // reserve count stays 0

        // Largest kernel reserve: accounted allocs and every reserve are refused.
        set_reserve('1);
        move_to(64, 1'b1);
        issue(pfa_pkg::CMD_ALLOC,     KIND_ACCT,  12'h000, 16'h0000);
        issue(pfa_pkg::CMD_ALLOC,     KIND_PLAIN, 12'h000, 16'h0000);
        issue(pfa_pkg::CMD_RESERVE,   KIND_PLAIN, 12'h000, 16'h0000);
        issue(pfa_pkg::CMD_UNRESERVE, KIND_PLAIN, 12'h000, 16'd100);

        set_reserve('0);
        issue(pfa_pkg::CMD_UNRESERVE, KIND_PLAIN, 12'h000, 16'hFFFF);

        // Random phases, each at its own kernel reserve; one of them without idling.
        for (int p = 0; p < 6; p++) begin
            level = $urandom_range(40, 300);
            steady_flow = (p == 2);
            move_to(level, 1'b0);
            case (p)
                0:       kres = pfa_pkg::KRES_W'(1);
                1:       kres = pfa_pkg::KRES_AT_RESET;
                2:       kres = '0;
                3:       kres = '1;
                4:       kres = pfa_pkg::KRES_W'($urandom_range(0, ledger.free_count));
                default: kres = pfa_pkg::KRES_W'($urandom_range(0, 65535));
            endcase
            set_reserve(kres);
            wander(250, level);
        end
        steady_flow = 1'b0;

        settle();
        repeat (8) @(posedge i_clk);
        if (ledger.failures == 0 && ledger.pending_outcomes.size() == 0)
            $display("page_frame_allocator_with_reserve: match");
        else
            $display("page_frame_allocator_with_reserve: mismatch");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/pfa_pkg.sv
rtl/pfa_stack_ram.sv
rtl/pfa_ctrl.sv
rtl/page_frame_allocator_with_reserve.sv
rtl/pfa_checker.sv
sim/page_frame_allocator_with_reserve_test.sv
